// ----- sv/mpc_pkg.sv -----
package mpc_pkg;

  localparam int RING_DEPTH = 16;
  localparam int PTR_W      = 4;
  localparam int FILL_W     = 5;
  localparam int PID_W      = 5;
  localparam int SLOT_W     = PID_W + 1;
  localparam int MSG_W      = 64 + 4;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FAIL  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    FN_CREATE    = 3'd0,
    FN_OPEN      = 3'd1,
    FN_CLOSE     = 3'd2,
    FN_SEND      = 3'd3,
    FN_RECEIVE   = 3'd4,
    FN_CLOSE_ALL = 3'd5
  } func_e;

  // Keeps the low len bytes of a 64-bit word.
  function automatic logic [63:0] byte_mask(input logic [3:0] len);
    logic [63:0] m;
    if (len >= 4'd8) begin
      m = '1;
    end else begin
      m = (64'd1 << {len[2:0], 3'b000}) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ----- sv/mailbox_pool_controller.sv -----
// Mailbox pool controller.
// Requests arrive on the slave stream, one item per request, and each gives
// exactly one result item on the master stream. The block is not ready while
// a request is in work; it takes the next item as soon as it is back in idle,
// even while the previous result still waits in the output register.
// The user RAM is scanned one slot per cycle. A bad pid, func or handle goes
// straight to the result; create clears the claimed box's user slots; open,
// close and send scan the box's user slots; receive scans them and then also
// reads the message RAM; close all scans every box in use in turn.
// Reset empties every box at once; no clearing pass is needed, since a box's
// user slots are cleared when it is created and only boxes in use are read.
// When the receiver stalls, the result holds in the output register and a
// finished request waits for it before its own result is written.
module mailbox_pool_controller import mpc_pkg::*; #(
  parameter int NUM_BOXES     = 16,
  parameter int NUM_PROCS     = 32,
  parameter int SLOTS_PER_BOX = 16,
  parameter int MSG_BYTES     = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // func[2:0], pid[7:3], handle[15:8], length[23:16], max_length[31:24],
  // payload[95:32]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], box_out[5:2], length_out[9:6], payload_out[73:10], zero fill
  output logic [79:0] m_axis_tdata
);

  localparam int BW   = NUM_BOXES > 1 ? $clog2(NUM_BOXES) : 1;
  localparam int SW   = SLOTS_PER_BOX > 1 ? $clog2(SLOTS_PER_BOX) : 1;
  localparam int UCW  = $clog2(SLOTS_PER_BOX + 1);
  localparam int CW   = $clog2(NUM_BOXES * SLOTS_PER_BOX + 1);
  localparam int SDEP = (2 ** BW) << SW;
  localparam int MDEP = (2 ** BW) * RING_DEPTH;

  typedef enum logic [2:0] {
    S_IDLE, S_CREATE_CLR, S_SCAN, S_ACT, S_RECV_CHK, S_CA_BOX, S_CA_NEXT, S_DONE
  } state_e;

  state_e state_q, state_d;

  logic [NUM_BOXES-1:0] in_use_q, in_use_d;
  logic [UCW-1:0]       ucount_q [NUM_BOXES];
  logic [UCW-1:0]       ucount_d [NUM_BOXES];
  logic [PTR_W-1:0]     wptr_q [NUM_BOXES];
  logic [PTR_W-1:0]     wptr_d [NUM_BOXES];
  logic [PTR_W-1:0]     rptr_q [NUM_BOXES];
  logic [PTR_W-1:0]     rptr_d [NUM_BOXES];
  logic [FILL_W-1:0]    fill_q [NUM_BOXES];
  logic [FILL_W-1:0]    fill_d [NUM_BOXES];

  logic          out_vld_q, out_vld_d;
  logic [79:0]   out_data_q, out_data_d;

  logic [2:0]    func_q, func_d;
  logic [PID_W-1:0] pid_q, pid_d;
  logic [7:0]    length_q, length_d;
  logic [7:0]    maxlen_q, maxlen_d;
  logic [63:0]   payload_q, payload_d;

  logic [BW-1:0] box_q, box_d;
  logic [SW:0]   idx_q, idx_d;
  logic          pv_q, pv_d;
  logic [SW-1:0] pidx_q, pidx_d;
  logic          found_q, found_d;
  logic [SW-1:0] fidx_q, fidx_d;
  logic          freef_q, freef_d;
  logic [SW-1:0] free_idx_q, free_idx_d;
  logic [CW-1:0] cnt_q, cnt_d;

  status_e       res_st_q, res_st_d;
  logic [3:0]    res_box_q, res_box_d;
  logic [3:0]    res_len_q, res_len_d;
  logic [63:0]   res_pay_q, res_pay_d;

  logic                 slot_we;
  logic [BW+SW-1:0]     slot_waddr, slot_raddr;
  logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
  logic                 msg_we;
  logic [BW+PTR_W-1:0]  msg_waddr, msg_raddr;
  logic [MSG_W-1:0]     msg_wdata, msg_rdata;

  logic          free_any;
  logic [BW-1:0] free_box;
  logic          hit, empty_slot;
  logic [3:0]    ml;

  logic [2:0]    in_func;
  logic [PID_W-1:0] in_pid;
  logic [7:0]    in_handle;

  assign in_func   = s_axis_tdata[2:0];
  assign in_pid    = s_axis_tdata[7:3];
  assign in_handle = s_axis_tdata[15:8];

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  mpc_ram #(.WIDTH(SLOT_W), .DEPTH(SDEP)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  mpc_ram #(.WIDTH(MSG_W), .DEPTH(MDEP)) u_msg_ram (
    .clk_i   (clk_i),
    .we_i    (msg_we),
    .waddr_i (msg_waddr),
    .wdata_i (msg_wdata),
    .raddr_i (msg_raddr),
    .rdata_o (msg_rdata)
  );

  // Lowest-numbered free box.
  always_comb begin
    free_any = 1'b0;
    free_box = '0;
    for (int b = NUM_BOXES - 1; b >= 0; b--) begin
      if (!in_use_q[b]) begin
        free_any = 1'b1;
        free_box = BW'(b);
      end
    end
  end

  assign hit        = pv_q && slot_rdata[SLOT_W-1] && (slot_rdata[PID_W-1:0] == pid_q);
  assign empty_slot = pv_q && !slot_rdata[SLOT_W-1];
  assign ml         = msg_rdata[MSG_W-1:64];

  always_comb begin
    state_d    = state_q;
    in_use_d   = in_use_q;
    ucount_d   = ucount_q;
    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    fill_d     = fill_q;
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    func_d     = func_q;
    pid_d      = pid_q;
    length_d   = length_q;
    maxlen_d   = maxlen_q;
    payload_d  = payload_q;
    box_d      = box_q;
    idx_d      = idx_q;
    pv_d       = pv_q;
    pidx_d     = pidx_q;
    found_d    = found_q;
    fidx_d     = fidx_q;
    freef_d    = freef_q;
    free_idx_d = free_idx_q;
    cnt_d      = cnt_q;
    res_st_d   = res_st_q;
    res_box_d  = res_box_q;
    res_len_d  = res_len_q;
    res_pay_d  = res_pay_q;

    slot_we    = 1'b0;
    slot_waddr = {box_q, idx_q[SW-1:0]};
    slot_wdata = '0;
    slot_raddr = {box_q, idx_q[SW-1:0]};
    msg_we     = 1'b0;
    msg_waddr  = {box_q, wptr_q[box_q]};
    msg_wdata  = {length_q[3:0], payload_q & byte_mask(length_q[3:0])};
    msg_raddr  = {box_q, rptr_q[box_q]};

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func_d     = in_func;
          pid_d      = in_pid;
          length_d   = s_axis_tdata[23:16];
          maxlen_d   = s_axis_tdata[31:24];
          payload_d  = s_axis_tdata[95:32];
          res_st_d   = ST_FAIL;
          res_box_d  = '0;
          res_len_d  = '0;
          res_pay_d  = '0;
          idx_d      = '0;
          pv_d       = 1'b0;
          found_d    = 1'b0;
          freef_d    = 1'b0;
          cnt_d      = '0;
          if ({2'b00, in_pid} >= 7'(NUM_PROCS) || in_func > FN_CLOSE_ALL) begin
            state_d = S_DONE;
          end else if (in_func == FN_CREATE) begin
            box_d   = free_box;
            state_d = free_any ? S_CREATE_CLR : S_DONE;
          end else if (in_func == FN_CLOSE_ALL) begin
            box_d   = '0;
            state_d = S_CA_BOX;
          end else if (in_handle >= 8'(NUM_BOXES)) begin
            state_d = S_DONE;
          end else if (!in_use_q[in_handle[BW-1:0]]) begin
            state_d = S_DONE;
          end else begin
            box_d   = in_handle[BW-1:0];
            state_d = S_SCAN;
          end
        end
      end
      S_CREATE_CLR: begin
        slot_we = 1'b1;
        idx_d   = idx_q + 1'b1;
        if (idx_q == (SW+1)'(SLOTS_PER_BOX - 1)) begin
          in_use_d[box_q] = 1'b1;
          ucount_d[box_q] = '0;
          wptr_d[box_q]   = '0;
          rptr_d[box_q]   = '0;
          fill_d[box_q]   = '0;
          res_st_d        = ST_OK;
          res_box_d       = 4'(box_q);
          state_d         = S_DONE;
        end
      end
      S_SCAN: begin
        // Read data for the slot issued last cycle is checked while the next
        // slot is read.
        if (idx_q < (SW+1)'(SLOTS_PER_BOX)) begin
          pidx_d = idx_q[SW-1:0];
          pv_d   = 1'b1;
          idx_d  = idx_q + 1'b1;
        end else begin
          pv_d = 1'b0;
        end
        if (hit) begin
          if (func_q == FN_CLOSE_ALL) begin
            slot_we    = 1'b1;
            slot_waddr = {box_q, pidx_q};
            cnt_d      = cnt_q + 1'b1;
            if (ucount_q[box_q] != '0) begin
              ucount_d[box_q] = ucount_q[box_q] - 1'b1;
            end
            if (ucount_q[box_q] <= UCW'(1)) begin
              in_use_d[box_q] = 1'b0;
            end
          end else if (!found_q) begin
            found_d = 1'b1;
            fidx_d  = pidx_q;
          end
        end
        if (empty_slot && !freef_q) begin
          freef_d    = 1'b1;
          free_idx_d = pidx_q;
        end
        if (idx_q == (SW+1)'(SLOTS_PER_BOX) && !pv_q) begin
          state_d = (func_q == FN_CLOSE_ALL) ? S_CA_NEXT : S_ACT;
        end
      end
      S_ACT: begin
        state_d = S_DONE;
        case (func_q)
          FN_OPEN: begin
            if (!found_q && freef_q) begin
              slot_we         = 1'b1;
              slot_waddr      = {box_q, free_idx_q};
              slot_wdata      = {1'b1, pid_q};
              ucount_d[box_q] = ucount_q[box_q] + 1'b1;
              res_st_d        = ST_OK;
            end
          end
          FN_CLOSE: begin
            if (found_q) begin
              slot_we    = 1'b1;
              slot_waddr = {box_q, fidx_q};
              if (ucount_q[box_q] != '0) begin
                ucount_d[box_q] = ucount_q[box_q] - 1'b1;
              end
              if (ucount_q[box_q] <= UCW'(1)) begin
                in_use_d[box_q] = 1'b0;
              end
              res_st_d = ST_OK;
            end
          end
          FN_SEND: begin
            if (length_q <= 8'(MSG_BYTES) && found_q) begin
              if (fill_q[box_q] >= FILL_W'(RING_DEPTH)) begin
                res_st_d = ST_FULL;
              end else begin
                msg_we        = 1'b1;
                wptr_d[box_q] = wptr_q[box_q] + 1'b1;
                fill_d[box_q] = fill_q[box_q] + 1'b1;
                res_st_d      = ST_OK;
              end
            end
          end
          FN_RECEIVE: begin
            if (found_q) begin
              if (fill_q[box_q] == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                state_d = S_RECV_CHK;
              end
            end
          end
          default: begin
            res_st_d = ST_FAIL;
          end
        endcase
      end
      S_RECV_CHK: begin
        if ({4'b0000, ml} <= maxlen_q) begin
          res_st_d      = ST_OK;
          res_len_d     = ml;
          res_pay_d     = msg_rdata[63:0] & byte_mask(ml);
          rptr_d[box_q] = rptr_q[box_q] + 1'b1;
          fill_d[box_q] = fill_q[box_q] - 1'b1;
        end
        state_d = S_DONE;
      end
      S_CA_BOX: begin
        idx_d = '0;
        pv_d  = 1'b0;
        state_d = in_use_q[box_q] ? S_SCAN : S_CA_NEXT;
      end
      S_CA_NEXT: begin
        if (box_q == BW'(NUM_BOXES - 1)) begin
          res_st_d = (cnt_q >= CW'(NUM_BOXES)) ? ST_FAIL : ST_OK;
          state_d  = S_DONE;
        end else begin
          box_d   = box_q + 1'b1;
          state_d = S_CA_BOX;
        end
      end
      S_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {6'b000000, res_pay_q, res_len_q, res_box_q, res_st_q};
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      in_use_q  <= '0;
      for (int b = 0; b < NUM_BOXES; b++) begin
        ucount_q[b] <= '0;
        wptr_q[b]   <= '0;
        rptr_q[b]   <= '0;
        fill_q[b]   <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      in_use_q  <= in_use_d;
      ucount_q  <= ucount_d;
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    func_q     <= func_d;
    pid_q      <= pid_d;
    length_q   <= length_d;
    maxlen_q   <= maxlen_d;
    payload_q  <= payload_d;
    box_q      <= box_d;
    idx_q      <= idx_d;
    pv_q       <= pv_d;
    pidx_q     <= pidx_d;
    found_q    <= found_d;
    fidx_q     <= fidx_d;
    freef_q    <= freef_d;
    free_idx_q <= free_idx_d;
    cnt_q      <= cnt_d;
    res_st_q   <= res_st_d;
    res_box_q  <= res_box_d;
    res_len_q  <= res_len_d;
    res_pay_q  <= res_pay_d;
  end

endmodule

// ----- sv/mpc_ram.sv -----
module mpc_ram import mpc_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
